// ----- sv/lfpd_pkg.sv -----
// shared types and constants for the line follower pd steering block
// no dependencies; imported by lfpd_decode, line_follow_pd_steering_top and the testbench
package lfpd_pkg;

    localparam int ERR_W    = 4;
    localparam int GAIN_W   = 10;
    localparam int STEER_W  = 15;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    // decoded position errors
    localparam logic signed [ERR_W-1:0] ERR_FAR_LEFT   = -4'sd7;
    localparam logic signed [ERR_W-1:0] ERR_NEAR_LEFT  = -4'sd5;
    localparam logic signed [ERR_W-1:0] ERR_ZERO       = 4'sd0;
    localparam logic signed [ERR_W-1:0] ERR_NEAR_RIGHT = 4'sd5;
    localparam logic signed [ERR_W-1:0] ERR_FAR_RIGHT  = 4'sd7;

    // reset values of the gain registers
    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 10'sd90;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = -10'sd25;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = 10'sd15;

    // decode rule selection
    typedef enum logic {
        MODE_RIGHT_WINS = 1'b0,
        MODE_PRIORITY   = 1'b1
    } decode_mode_t;

    // register word index (byte address / 4)
    typedef enum logic [1:0] {
        REG_DECODE_MODE = 2'd0,
        REG_GAIN_P      = 2'd1,
        REG_GAIN_I      = 2'd2,
        REG_GAIN_D      = 2'd3
    } reg_idx_t;

    // one sample of the five line sensors
    typedef struct packed {
        logic far_left;
        logic near_left;
        logic center;
        logic near_right;
        logic far_right;
    } sensor_t;

endpackage

// ----- sv/lfpd_decode.sv -----
// sensor pattern to position error decode, both decode rules
// depends on lfpd_pkg
module lfpd_decode
    import lfpd_pkg::*;
(
    input  sensor_t                  sensors,
    input  decode_mode_t             mode,
    output logic signed [ERR_W-1:0]  line_err
);

    logic [2:0]               active;
    logic signed [ERR_W-1:0]  err_right_wins;
    logic signed [ERR_W-1:0]  err_priority;

    // number of sensors seeing the line
    assign active = 3'(sensors.far_left) + 3'(sensors.near_left) + 3'(sensors.center)
                  + 3'(sensors.near_right) + 3'(sensors.far_right);

    // right side overrides left side, more than three active means centered
    always_comb
    begin
        err_right_wins = ERR_ZERO;
        if (sensors.near_left)
        begin
            err_right_wins = ERR_NEAR_LEFT;
        end
        else if (sensors.far_left)
        begin
            err_right_wins = ERR_FAR_LEFT;
        end
        if (sensors.near_right)
        begin
            err_right_wins = ERR_NEAR_RIGHT;
        end
        else if (sensors.far_right)
        begin
            err_right_wins = ERR_FAR_RIGHT;
        end
        if (active > 3'd3)
        begin
            err_right_wins = ERR_ZERO;
        end
    end

    // priority chain from far left, three or more active means centered
    always_comb
    begin
        if (active >= 3'd3)
        begin
            err_priority = ERR_ZERO;
        end
        else if (sensors.far_left)
        begin
            err_priority = ERR_FAR_LEFT;
        end
        else if (sensors.near_left)
        begin
            err_priority = ERR_NEAR_LEFT;
        end
        else if (active == 3'd0 || sensors.center)
        begin
            err_priority = ERR_ZERO;
        end
        else if (sensors.near_right)
        begin
            err_priority = ERR_NEAR_RIGHT;
        end
        else
        begin
            err_priority = ERR_FAR_RIGHT;
        end
    end

    // rule select
    always_comb
    begin
        unique case (mode)
            MODE_RIGHT_WINS: line_err = err_right_wins;
            MODE_PRIORITY:   line_err = err_priority;
            default:         line_err = err_right_wins;
        endcase
    end

endmodule

// ----- sv/line_follow_pd_steering_top.sv -----
// top level of the line follower pd steering block: apb registers, input
// register, decode and pd math, result register; depends on lfpd_pkg, lfpd_decode
//
// usage:
//   input channel (in_valid/in_ready) carries one five-sensor sample per transfer.
//   output channel (out_valid/out_ready) returns steer and line_error per sample,
//   one result for each input, in order.
//   the sample is captured in an input register; decode, the two multiplies and
//   the add sit between it and the result register, and out_valid rises as the
//   sample moves from the input register into the result register. a new sample
//   is taken every cycle while the receiver does not stall.
//   steer = (gain_p + gain_i) * e + gain_d * (e - previous e); the previous error
//   advances as each sample moves into the result register.
//   when the receiver stalls, the result register holds, the input register
//   holds behind it, and in_ready drops only once both are full.
//   apb registers (word addresses 0..3): decode_mode, gain_p, gain_i, gain_d;
//   write them only while the block is idle. pready is always high.
//   reset (rst_n low) empties both stages, clears the previous error and loads
//   the register reset values (mode 0, gains 90, -25, 15).
module line_follow_pd_steering_top
    import lfpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // sample channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       far_left,
    input  logic                       near_left,
    input  logic                       center,
    input  logic                       near_right,
    input  logic                       far_right,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [STEER_W-1:0]  steer,
    output logic signed [ERR_W-1:0]    line_error,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    decode_mode_t               mode_reg;
    logic signed [GAIN_W-1:0]   gain_p_reg;
    logic signed [GAIN_W-1:0]   gain_i_reg;
    logic signed [GAIN_W-1:0]   gain_d_reg;
    reg_idx_t                   reg_idx;
    logic                       cfg_write;

    logic                       in_vld_reg;
    sensor_t                    sample_reg;
    logic                       out_vld_reg;
    logic signed [STEER_W-1:0]  steer_reg;
    logic signed [ERR_W-1:0]    err_out_reg;
    logic signed [ERR_W-1:0]    prev_err_reg;

    logic                       advance;
    logic                       in_xfer;
    logic                       move;
    logic signed [ERR_W-1:0]    err_cur;
    logic signed [GAIN_W:0]     gain_pi;
    logic signed [ERR_W:0]      err_diff;
    logic signed [15:0]         term_p;
    logic signed [15:0]         term_d;
    logic signed [15:0]         steer_sum;
    logic signed [STEER_W-1:0]  steer_next;

    // register access
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RIGHT_WINS;
            gain_p_reg <= GAIN_P_RST;
            gain_i_reg <= GAIN_I_RST;
            gain_d_reg <= GAIN_D_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_DECODE_MODE: mode_reg   <= decode_mode_t'(pwdata[0]);
                REG_GAIN_P:      gain_p_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_I:      gain_i_reg <= pwdata[GAIN_W-1:0];
                REG_GAIN_D:      gain_d_reg <= pwdata[GAIN_W-1:0];
                default:         ;
            endcase
        end
    end

    // read back, gains sign extended
    always_comb
    begin
        unique case (reg_idx)
            REG_DECODE_MODE: prdata = APB_DW'(mode_reg);
            REG_GAIN_P:      prdata = APB_DW'(gain_p_reg);
            REG_GAIN_I:      prdata = APB_DW'(gain_i_reg);
            REG_GAIN_D:      prdata = APB_DW'(gain_d_reg);
            default:         prdata = '0;
        endcase
    end

    // handshake: result register frees when empty or taken
    assign advance  = !out_vld_reg || out_ready;
    assign move     = in_vld_reg && advance;
    assign in_ready = !in_vld_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sample_reg <= '{far_left, near_left, center, near_right, far_right};
        end
    end

    // error decode
    lfpd_decode u_decode (
        .sensors  (sample_reg),
        .mode     (mode_reg),
        .line_err (err_cur)
    );

    // pd math
    always_comb
    begin
        gain_pi    = (GAIN_W+1)'(gain_p_reg) + (GAIN_W+1)'(gain_i_reg);
        err_diff   = (ERR_W+1)'(err_cur) - (ERR_W+1)'(prev_err_reg);
        term_p     = 16'(gain_pi) * 16'(err_cur);
        term_d     = 16'(gain_d_reg) * 16'(err_diff);
        steer_sum  = term_p + term_d;
        steer_next = STEER_W'(steer_sum);
    end

    // result stage and previous error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            prev_err_reg <= ERR_ZERO;
        end
        else
        begin
            if (advance)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (move)
            begin
                prev_err_reg <= err_cur;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            steer_reg   <= steer_next;
            err_out_reg <= err_cur;
        end
    end

    assign out_valid  = out_vld_reg;
    assign steer      = steer_reg;
    assign line_error = err_out_reg;

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for line_follow_pd_steering_top: sample and result
// channels with random idling, apb register writes between phases
// depends on lfpd_pkg and line_follow_pd_steering_top
`timescale 1ns / 100ps

module testbench;
    import lfpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 125;

    typedef struct {
        logic signed [STEER_W-1:0] steer;
        logic signed [ERR_W-1:0]   line_error;
    } steering_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      far_left = 1'b0;
    logic                      near_left = 1'b0;
    logic                      center = 1'b0;
    logic                      near_right = 1'b0;
    logic                      far_right = 1'b0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [STEER_W-1:0] steer;
    logic signed [ERR_W-1:0]   line_error;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_AW-1:0]         paddr = '0;
    logic [APB_DW-1:0]         pwdata = '0;
    logic [APB_DW-1:0]         prdata;
    logic                      pready;

    // steering model state and register copies
    decode_mode_t              mode_model = MODE_RIGHT_WINS;
    logic signed [GAIN_W-1:0]  gain_p_model = GAIN_P_RST;
    logic signed [GAIN_W-1:0]  gain_i_model = GAIN_I_RST;
    logic signed [GAIN_W-1:0]  gain_d_model = GAIN_D_RST;
    logic signed [ERR_W-1:0]   last_error_model = ERR_ZERO;

    sensor_t                   pending_samples[$];
    steering_t                 expected_steering[$];
    int                        send_idle_pct = 0;
    int                        recv_stall_pct = 0;
    int                        error_count = 0;
    int                        quiet_cycles = 0;

    line_follow_pd_steering_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .far_left   (far_left),
        .near_left  (near_left),
        .center     (center),
        .near_right (near_right),
        .far_right  (far_right),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .steer      (steer),
        .line_error (line_error),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #2 clk = ~clk;

    // position error of one sensor sample under the selected decode rule
    function automatic logic signed [ERR_W-1:0] line_position(decode_mode_t m, sensor_t s);
        int                      active;
        logic signed [ERR_W-1:0] e;
        active = s.far_left + s.near_left + s.center + s.near_right + s.far_right;
        e = ERR_ZERO;
        if (m == MODE_RIGHT_WINS)
        begin
            if (active <= 3)
            begin
                if (s.near_left)
                    e = ERR_NEAR_LEFT;
                else if (s.far_left)
                    e = ERR_FAR_LEFT;
                // right-hand sensors override the left value
                if (s.near_right)
                    e = ERR_NEAR_RIGHT;
                else if (s.far_right)
                    e = ERR_FAR_RIGHT;
            end
        end
        else
        begin
            if (active >= 3)
                e = ERR_ZERO;
            else if (s.far_left)
                e = ERR_FAR_LEFT;
            else if (s.near_left)
                e = ERR_NEAR_LEFT;
            else if (active == 0 || s.center)
                e = ERR_ZERO;
            else if (s.near_right)
                e = ERR_NEAR_RIGHT;
            else
                e = ERR_FAR_RIGHT;
        end
        return e;
    endfunction

    // pd steering result for one sample; advances the previous error
    function automatic steering_t steering_for(sensor_t s);
        steering_t r;
        int        e;
        int        prev;
        int        total;
        r.line_error = line_position(mode_model, s);
        e = r.line_error;
        prev = last_error_model;
        total = (int'(gain_p_model) + int'(gain_i_model)) * e + int'(gain_d_model) * (e - prev);
        r.steer = total[STEER_W-1:0];
        last_error_model = r.line_error;
        return r;
    endfunction

    // sample driver: predict on each transfer, then present the next sample
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_steering.push_back(steering_for(
                    sensor_t'({far_left, near_left, center, near_right, far_right})));
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    {far_left, near_left, center, near_right, far_right} <=
                        pending_samples.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: compare each transfer against the oldest expectation
    always @(posedge clk)
    begin
        steering_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_steering.size() == 0)
            begin
                $display("%0t: unexpected result steer %0d line_error %0d",
                         $time, steer, line_error);
                error_count++;
            end
            else
            begin
                want = expected_steering.pop_front();
                if (steer !== want.steer)
                begin
                    $display("%0t: steer mismatch expected %0d actual %0d",
                             $time, want.steer, steer);
                    error_count++;
                end
                if (line_error !== want.line_error)
                begin
                    $display("%0t: line_error mismatch expected %0d actual %0d",
                             $time, want.line_error, line_error);
                    error_count++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // count cycles without progress while work is outstanding
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (pending_samples.size() == 0 && !in_valid && expected_steering.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic apb_write(reg_idx_t idx, logic [APB_DW-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_settings(decode_mode_t m, int gp, int gi, int gd);
        apb_write(REG_DECODE_MODE, APB_DW'(m));
        apb_write(REG_GAIN_P, APB_DW'(gp));
        apb_write(REG_GAIN_I, APB_DW'(gi));
        apb_write(REG_GAIN_D, APB_DW'(gd));
        mode_model   = m;
        gain_p_model = gp[GAIN_W-1:0];
        gain_i_model = gi[GAIN_W-1:0];
        gain_d_model = gd[GAIN_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || in_valid || expected_steering.size() > 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic sensor_t random_sample();
        logic [4:0] bits;
        bits = '0;
        // mostly one or two sensors on the line, the rest any pattern
        if ($urandom_range(99) < 60)
        begin
            bits[$urandom_range(4)] = 1'b1;
            if ($urandom_range(1))
                bits[$urandom_range(4)] = 1'b1;
        end
        else
        begin
            bits = 5'($urandom_range(31));
        end
        return sensor_t'(bits);
    endfunction

    function automatic int random_gain();
        return int'($urandom_range(1023)) - 512;
    endfunction

    initial
    begin
        sensor_t      corner_cases[12];
        decode_mode_t m;
        corner_cases = '{
            sensor_t'(5'b00000),  // all clear
            sensor_t'(5'b10000),  // far left
            sensor_t'(5'b00001),  // far right, full swing of the error
            sensor_t'(5'b01000),
            sensor_t'(5'b00100),
            sensor_t'(5'b00010),
            sensor_t'(5'b11000),  // near left beats far left in one rule only
            sensor_t'(5'b10001),  // right overrides left under the right-wins rule
            sensor_t'(5'b01010),
            sensor_t'(5'b11100),  // three active
            sensor_t'(5'b01110),
            sensor_t'(5'b11110)   // four active
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed patterns at reset settings, then under the priority rule
        foreach (corner_cases[k])
            pending_samples.push_back(corner_cases[k]);
        pending_samples.push_back(sensor_t'(5'b11111));
        wait_drained();
        load_settings(MODE_PRIORITY, 90, -25, 15);
        foreach (corner_cases[k])
            pending_samples.push_back(corner_cases[k]);
        wait_drained();

        // random phases over register settings and idle profiles
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: load_settings(MODE_RIGHT_WINS, 511, 511, 511);
                1: load_settings(MODE_PRIORITY, -512, -512, -512);
                2: load_settings(MODE_RIGHT_WINS, -512, -512, 511);
                3: load_settings(MODE_PRIORITY, 511, 511, -512);
                4: load_settings(MODE_PRIORITY, 0, 0, 0);
                default:
                begin
                    m = decode_mode_t'($urandom_range(1));
                    load_settings(m, random_gain(), random_gain(), random_gain());
                end
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_samples.push_back(random_sample());
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
